>>> rtl/btok_pkg.sv
`timescale 1ns / 1ps
package btok_pkg;

  localparam logic [3:0] KIND_COLON      = 4'd0;
  localparam logic [3:0] KIND_EQUALS     = 4'd1;
  localparam logic [3:0] KIND_NEWLINE    = 4'd2;
  localparam logic [3:0] KIND_DOLLAR     = 4'd3;
  localparam logic [3:0] KIND_COMMENT    = 4'd4;
  localparam logic [3:0] KIND_RULE       = 4'd5;
  localparam logic [3:0] KIND_BUILD      = 4'd6;
  localparam logic [3:0] KIND_DEFAULT    = 4'd7;
  localparam logic [3:0] KIND_COMMAND    = 4'd8;
  localparam logic [3:0] KIND_FLAG       = 4'd9;
  localparam logic [3:0] KIND_PATH       = 4'd10;
  localparam logic [3:0] KIND_IDENTIFIER = 4'd11;
  localparam logic [3:0] KIND_INVALID    = 4'd12;
  localparam logic [3:0] KIND_END        = 4'd13;

  localparam logic [1:0] KW_RULE    = 2'd0;
  localparam logic [1:0] KW_BUILD   = 2'd1;
  localparam logic [1:0] KW_DEFAULT = 2'd2;
  localparam logic [1:0] KW_COMMAND = 2'd3;
  localparam int KW_COUNT = 4;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = 2;
  localparam int QCNT_BITS   = 3;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
  } tok_t;

  // tokens caused by one byte, t0 first; t1 used only when two is set
  typedef struct packed {
    logic two;
    tok_t t0;
    tok_t t1;
  } pair_t;

  function automatic logic [2:0] kw_len(input logic [1:0] k);
    logic [2:0] n;
    unique case (k)
      KW_RULE:    n = 3'd4;
      KW_BUILD:   n = 3'd5;
      KW_DEFAULT: n = 3'd7;
      KW_COMMAND: n = 3'd7;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] p);
    logic [63:0] txt;
    unique case (k)
      KW_RULE:    txt = {"rule", 32'h0};
      KW_BUILD:   txt = {"build", 24'h0};
      KW_DEFAULT: txt = {"default", 8'h0};
      KW_COMMAND: txt = {"command", 8'h0};
    endcase
    return txt[(7 - int'(p)) * 8 +: 8];
  endfunction

endpackage

>>> rtl/btok_if.sv
`timescale 1ns / 1ps
interface btok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       final_byte;

  modport source (output valid, output char_byte, output final_byte, input ready);
  modport sink (input valid, input char_byte, input final_byte, output ready);
endinterface

interface btok_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic        last_of_run;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output last_of_run, input ready);
  modport sink (input valid, input token_kind, input token_start,
                input token_length, input last_of_run, output ready);
endinterface

>>> rtl/btok_front.sv
`timescale 1ns / 1ps
module btok_front import btok_pkg::*; #(
  parameter int OFFSET_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  btok_in_if.sink    in_ch,
  input  logic       full,
  output logic       push,
  output pair_t      push_data
);

  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_WORD    = 2'd1;
  localparam logic [1:0] MODE_COMMENT = 2'd2;

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;
  localparam logic [OFFSET_BITS-1:0] ONE     = OFFSET_BITS'(1);

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;

  logic [1:0]             mode, mode_next;
  logic [OFFSET_BITS-1:0] off;
  logic [OFFSET_BITS-1:0] wstart, wstart_next;
  logic [3:0]             kmask, kmask_next;
  logic                   has_dot, dot_next;
  logic                   starts_dash, dash_next;

  logic [7:0]             c;
  logic                   fin;
  logic                   fire;
  logic [OFFSET_BITS-1:0] off_end;
  logic [OFFSET_BITS-1:0] len_close;
  logic [OFFSET_BITS-1:0] len_fin;
  logic [3:0]             ext_mask;
  logic [3:0]             open_mask;
  logic                   dot_ext;
  logic                   idle_go;
  logic                   a_v, b_v;
  tok_t                   a_tok, b_tok;

  function automatic logic is_word_first(input logic [7:0] ch);
    return (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A) ||
           ch == CH_UNDER || ch == CH_DOT || ch == CH_DASH;
  endfunction

  function automatic logic is_word_more(input logic [7:0] ch);
    return is_word_first(ch) || (ch >= 8'h30 && ch <= 8'h39) || ch == CH_PLUS;
  endfunction

  function automatic logic [15:0] sat16(input logic [OFFSET_BITS-1:0] v);
    logic [OFFSET_BITS+15:0] w;
    w = {16'h0, v};
    if (w > (OFFSET_BITS+16)'(16'hFFFF)) return 16'hFFFF;
    return w[15:0];
  endfunction

  function automatic tok_t mk_tok(input logic [3:0] kind,
                                  input logic [OFFSET_BITS-1:0] start,
                                  input logic [OFFSET_BITS-1:0] length);
    tok_t t;
    t.kind   = kind;
    t.start  = sat16(start);
    t.length = sat16(length);
    return t;
  endfunction

  function automatic logic [3:0] word_kind(input logic [3:0] m,
                                           input logic [OFFSET_BITS-1:0] length,
                                           input logic dash, input logic dot);
    logic [3:0] kind;
    if (dash) kind = KIND_FLAG;
    else if (dot) kind = KIND_PATH;
    else kind = KIND_IDENTIFIER;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (m[k] && length == OFFSET_BITS'(kw_len(2'(k)))) kind = KIND_RULE + 4'(k);
    end
    return kind;
  endfunction

  assign c     = in_ch.char_byte;
  assign fin   = in_ch.final_byte;
  assign in_ch.ready = !full;
  assign fire  = in_ch.valid && in_ch.ready;

  assign off_end   = (off == OFF_MAX) ? OFF_MAX : off + ONE;
  assign len_close = off - wstart;
  assign len_fin   = off_end - wstart;
  assign dot_ext   = has_dot || (c == CH_DOT);

  always_comb begin
    for (int k = 0; k < KW_COUNT; k++) begin
      ext_mask[k] = kmask[k] && (off != OFF_MAX) &&
                    (len_close < OFFSET_BITS'(kw_len(2'(k)))) &&
                    (c == kw_char(2'(k), len_close[2:0]));
      open_mask[k] = (c == kw_char(2'(k), 3'd0));
    end
  end

  always_comb begin
    a_v         = 1'b0;
    b_v         = 1'b0;
    a_tok       = '0;
    b_tok       = '0;
    mode_next   = mode;
    wstart_next = wstart;
    kmask_next  = kmask;
    dot_next    = has_dot;
    dash_next   = starts_dash;
    idle_go     = 1'b1;

    unique case (mode)
      MODE_WORD: begin
        if (is_word_more(c)) begin
          kmask_next = ext_mask;
          dot_next   = dot_ext;
          idle_go    = 1'b0;
          if (fin) begin
            a_v   = 1'b1;
            a_tok = mk_tok(word_kind(ext_mask, len_fin, starts_dash, dot_ext),
                           wstart, len_fin);
          end
        end else begin
          a_v       = 1'b1;
          a_tok     = mk_tok(word_kind(kmask, len_close, starts_dash, has_dot),
                             wstart, len_close);
          mode_next = MODE_IDLE;
        end
      end
      MODE_COMMENT: begin
        if (c != CH_LF) begin
          idle_go = 1'b0;
          if (fin) begin
            a_v   = 1'b1;
            a_tok = mk_tok(KIND_COMMENT, wstart, len_fin);
          end
        end else begin
          a_v       = 1'b1;
          a_tok     = mk_tok(KIND_COMMENT, wstart, len_close);
          mode_next = MODE_IDLE;
        end
      end
      default: begin
        mode_next = MODE_IDLE;
      end
    endcase

    if (idle_go) begin
      priority if (c == CH_SPACE || c == CH_TAB || c == CH_CR) begin
        if (fin) begin
          b_v   = 1'b1;
          b_tok = mk_tok(KIND_END, off_end, '0);
        end
      end else if (c == CH_COLON) begin
        b_v   = 1'b1;
        b_tok = mk_tok(KIND_COLON, off, ONE);
      end else if (c == CH_EQUALS) begin
        b_v   = 1'b1;
        b_tok = mk_tok(KIND_EQUALS, off, ONE);
      end else if (c == CH_LF) begin
        b_v   = 1'b1;
        b_tok = mk_tok(KIND_NEWLINE, off, ONE);
      end else if (c == CH_DOLLAR) begin
        b_v   = 1'b1;
        b_tok = mk_tok(KIND_DOLLAR, off, ONE);
      end else if (c == CH_HASH) begin
        wstart_next = off;
        if (fin) begin
          b_v   = 1'b1;
          b_tok = mk_tok(KIND_COMMENT, off, ONE);
        end else begin
          mode_next = MODE_COMMENT;
        end
      end else if (is_word_first(c)) begin
        kmask_next  = open_mask;
        wstart_next = off;
        dot_next    = (c == CH_DOT);
        dash_next   = (c == CH_DASH);
        if (fin) begin
          b_v   = 1'b1;
          b_tok = mk_tok(word_kind(open_mask, ONE, c == CH_DASH, c == CH_DOT), off, ONE);
        end else begin
          mode_next = MODE_WORD;
        end
      end else begin
        b_v   = 1'b1;
        b_tok = mk_tok(KIND_INVALID, off, ONE);
      end
    end
  end

  assign push           = fire && (a_v || b_v);
  assign push_data.two  = a_v && b_v;
  assign push_data.t0   = a_v ? a_tok : b_tok;
  assign push_data.t1   = b_tok;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      off         <= '0;
      wstart      <= '0;
      kmask       <= '0;
      has_dot     <= 1'b0;
      starts_dash <= 1'b0;
    end else if (fire) begin
      if (fin) begin
        mode        <= MODE_IDLE;
        off         <= '0;
        wstart      <= '0;
        kmask       <= '0;
        has_dot     <= 1'b0;
        starts_dash <= 1'b0;
      end else begin
        mode        <= mode_next;
        off         <= off_end;
        wstart      <= wstart_next;
        kmask       <= kmask_next;
        has_dot     <= dot_next;
        starts_dash <= dash_next;
      end
    end
  end

endmodule

>>> rtl/btok_queue.sv
`timescale 1ns / 1ps
module btok_queue import btok_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  pair_t push_data,
  output logic  full,
  input  logic  pop,
  output pair_t pop_data,
  output logic  empty
);

  pair_t                mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;

  assign full     = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_BITS'(1);
      if (pop) rd_ptr <= rd_ptr + QPTR_BITS'(1);
      if (push && !pop) count <= count + QCNT_BITS'(1);
      else if (pop && !push) count <= count - QCNT_BITS'(1);
    end
  end

endmodule

>>> rtl/btok_back.sv
`timescale 1ns / 1ps
module btok_back import btok_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       empty,
  input  pair_t      pop_data,
  output logic       pop,
  btok_out_if.source out_ch
);

  logic valid;
  tok_t cur;
  logic last;
  logic pend;
  tok_t spare;
  logic load;

  assign load = !valid || out_ch.ready;
  assign pop  = load && !pend && !empty;

  assign out_ch.valid        = valid;
  assign out_ch.token_kind   = cur.kind;
  assign out_ch.token_start  = cur.start;
  assign out_ch.token_length = cur.length;
  assign out_ch.last_of_run  = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      pend  <= 1'b0;
    end else if (load) begin
      if (pend) begin
        cur   <= spare;
        last  <= 1'b1;
        valid <= 1'b1;
        pend  <= 1'b0;
      end else if (!empty) begin
        cur   <= pop_data.t0;
        last  <= !pop_data.two;
        pend  <= pop_data.two;
        spare <= pop_data.t1;
        valid <= 1'b1;
      end else begin
        valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/build_file_tokenizer.sv
`timescale 1ns / 1ps
// build-file tokenizer
// in_ch carries one source byte per transaction (char_byte, final_byte marks
// the last byte of a source); out_ch carries one token per transaction
// (token_kind, token_start, token_length, last_of_run).
// a byte is classified in the cycle it is accepted; a byte that gives tokens
// writes them (one or two) as one entry into a four-entry queue.
// the output stage drains the queue one token per cycle while out_ch is ready;
// a token goes from the queue into the output register, then waits for ready.
// throughput: one byte per cycle while out_ch is ready and bytes give at most
// one token each; a byte that gives two tokens (a word or comment closed by a
// token byte) needs two output transfers, and the queue absorbs the extra one.
// in_ch.ready drops only while the queue is full, i.e. when the receiver
// stalls out_ch long enough for four entries to collect.
// after final_byte the scanner returns to offset 0 for the next source.
// reset (rst, synchronous) empties the queue and the output stage and
// returns the scanner to its idle state at offset 0.
module build_file_tokenizer import btok_pkg::*; #(
  parameter int OFFSET_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  btok_in_if.sink    in_ch,
  btok_out_if.source out_ch
);

  logic  push;
  pair_t push_data;
  logic  full;
  logic  pop;
  pair_t pop_data;
  logic  empty;

  btok_front #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  btok_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  btok_back u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .pop_data (pop_data),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule
